/* hdl/bsdpd_pkg.sv */
// Shared types and constants for the single/double press detector.
`timescale 1ns / 1ps

package bsdpd_pkg;

    // Item kinds on the input stream
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Classifier modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_CONFIRM1 = 2'd1;
    localparam logic [1:0] MODE_WAIT2    = 2'd2;
    localparam logic [1:0] MODE_CONFIRM2 = 2'd3;

    // Press event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    // Register indexes
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_WINDOW   = 1'b1;

    // Widths and saturation limits
    localparam int DEBOUNCE_W = 10;
    localparam int WINDOW_W   = 12;
    localparam logic [DEBOUNCE_W-1:0] SINCE_MAX  = 10'd1023;
    localparam logic [WINDOW_W-1:0]   WINDOW_MAX = 12'd4095;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 12'd250;

    // Configuration handed to the classifier
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_time;
        logic [WINDOW_W-1:0]   double_window_ms;
    } cfg_t;

    // Status reported by the classifier
    typedef struct packed {
        logic [1:0] mode;
    } status_t;

endpackage

/* hdl/bsdpd_core.sv */
// Press classifier state and its single-pass next-state logic.
`timescale 1ns / 1ps

module bsdpd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic                level,
    input  bsdpd_pkg::cfg_t     cfg,
    output logic [1:0]          press_event,
    output bsdpd_pkg::status_t  status
);

    logic [1:0]                           mode_reg,    mode_next;
    logic [bsdpd_pkg::DEBOUNCE_W-1:0]     since_reg,   since_next;
    logic [bsdpd_pkg::DEBOUNCE_W-1:0]     confirm_reg, confirm_next;
    logic [bsdpd_pkg::WINDOW_W-1:0]       window_reg,  window_next;
    logic [bsdpd_pkg::WINDOW_W-1:0]       window_inc;
    logic                                 confirm_done;
    logic [1:0]                           ev;

    // Saturating window count and end of the confirmation wait
    assign window_inc   = (window_reg < bsdpd_pkg::WINDOW_MAX)
                          ? window_reg + 1'b1 : window_reg;
    assign confirm_done = (confirm_reg <= {{(bsdpd_pkg::DEBOUNCE_W-1){1'b0}}, 1'b1});

    // Next state for one item
    always_comb
    begin
        mode_next    = mode_reg;
        since_next   = since_reg;
        confirm_next = confirm_reg;
        window_next  = window_reg;
        ev           = bsdpd_pkg::EV_NONE;
        if (step)
        begin
            if (op == bsdpd_pkg::OP_EDGE)
            begin
                // An edge starts a check only when idle or waiting, and spaced enough
                if ((mode_reg == bsdpd_pkg::MODE_IDLE || mode_reg == bsdpd_pkg::MODE_WAIT2)
                    && since_reg >= cfg.debounce_time)
                begin
                    since_next   = '0;
                    confirm_next = cfg.debounce_time;
                    mode_next    = (mode_reg == bsdpd_pkg::MODE_IDLE)
                                   ? bsdpd_pkg::MODE_CONFIRM1 : bsdpd_pkg::MODE_CONFIRM2;
                end
            end
            else
            begin
                if (since_reg < bsdpd_pkg::SINCE_MAX)
                begin
                    since_next = since_reg + 1'b1;
                end
                if (mode_reg == bsdpd_pkg::MODE_CONFIRM1 || mode_reg == bsdpd_pkg::MODE_CONFIRM2)
                begin
                    confirm_next = confirm_done ? '0 : confirm_reg - 1'b1;
                end
                case (mode_reg)
                    bsdpd_pkg::MODE_CONFIRM1:
                    begin
                        if (confirm_done)
                        begin
                            if (!level)
                            begin
                                mode_next   = bsdpd_pkg::MODE_WAIT2;
                                window_next = '0;
                            end
                            else
                            begin
                                mode_next = bsdpd_pkg::MODE_IDLE;
                            end
                        end
                    end
                    bsdpd_pkg::MODE_WAIT2:
                    begin
                        window_next = window_inc;
                        if (window_inc >= cfg.double_window_ms)
                        begin
                            ev        = bsdpd_pkg::EV_SINGLE;
                            mode_next = bsdpd_pkg::MODE_IDLE;
                        end
                    end
                    bsdpd_pkg::MODE_CONFIRM2:
                    begin
                        window_next = window_inc;
                        if (confirm_done)
                        begin
                            if (!level)
                            begin
                                ev        = bsdpd_pkg::EV_DOUBLE;
                                mode_next = bsdpd_pkg::MODE_IDLE;
                            end
                            else if (window_inc >= cfg.double_window_ms)
                            begin
                                ev        = bsdpd_pkg::EV_SINGLE;
                                mode_next = bsdpd_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                mode_next = bsdpd_pkg::MODE_WAIT2;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= bsdpd_pkg::MODE_IDLE;
            since_reg   <= '0;
            confirm_reg <= '0;
            window_reg  <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            since_reg   <= since_next;
            confirm_reg <= confirm_next;
            window_reg  <= window_next;
        end
    end

    assign press_event = ev;
    assign status.mode = mode_reg;

endmodule

/* hdl/button_single_double_press_detector.sv */
// Top level of the button single/double press detector.
`timescale 1ns / 1ps

// Classifies button presses from a stream of millisecond ticks (with the
// sampled pin level) and falling-edge items, and returns one press event
// for every item: none, single press or double press. One item is taken in
// every clock cycle as long as results are taken; each item passes through an
// input register, the classifier logic and a result register. The input side
// keeps accepting while a result waits to be taken, until both the input and
// the result registers are full. The debounce time (index 0, reset 30) and
// double_window_ms (index 1, reset 250) are written through the configuration
// port; the user must write them only while no item is in flight, as the block
// itself does not enforce it.
module button_single_double_press_detector
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] press_event, [7:2] zero
    // Configuration port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    logic                in_valid_reg;
    logic                in_op_reg;
    logic                in_level_reg;
    logic                out_valid_reg;
    logic [1:0]          out_event_reg;
    logic                advance;
    logic [1:0]          core_event;
    bsdpd_pkg::cfg_t     cfg_reg;
    bsdpd_pkg::status_t  core_status;

    // An item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg    <= s_tuser[0];
            in_level_reg <= s_tdata[0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time    <= bsdpd_pkg::DEBOUNCE_RESET;
            cfg_reg.double_window_ms <= bsdpd_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsdpd_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_time <= cfg_data[bsdpd_pkg::DEBOUNCE_W-1:0];
                bsdpd_pkg::REG_WINDOW:
                    cfg_reg.double_window_ms <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Classifier
    bsdpd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .op          (in_op_reg),
        .level       (in_level_reg),
        .cfg         (cfg_reg),
        .press_event (core_event),
        .status      (core_status)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= core_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_event_reg};

    // A double press can only come out of the second confirmation
    a_double_from_confirm2 : assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_event == bsdpd_pkg::EV_DOUBLE
        |-> core_status.mode == bsdpd_pkg::MODE_CONFIRM2)
        else $error("double press outside second confirmation");

    // Any reported press returns the classifier to idle
    a_press_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_event != bsdpd_pkg::EV_NONE
        |=> core_status.mode == bsdpd_pkg::MODE_IDLE)
        else $error("classifier not idle after a press");

    // A held item in the input register keeps its contents
    a_input_hold : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance
        |=> in_valid_reg && $stable(in_op_reg) && $stable(in_level_reg))
        else $error("stalled item lost or changed");

    // The result code is never out of range
    a_event_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'b11)
        else $error("invalid press event code");

endmodule
